// ----- sv/mpcs_pkg.sv -----
// shared types and constants for the mouse packet cursor selection block
package mpcs_pkg;

  // fixed field widths of the cursor coordinates and cell address
  localparam int X_W    = 7;
  localparam int Y_W    = 5;
  localparam int ADDR_W = 12;

  // header bit positions
  localparam int HDR_LEFT    = 0;
  localparam int HDR_RIGHT   = 1;
  localparam int HDR_XSIGN   = 4;
  localparam int HDR_YSIGN   = 5;
  localparam int HDR_XOVF    = 6;
  localparam int HDR_YOVF    = 7;

  // position of the next byte within its packet
  localparam logic [1:0] IDX_HEADER = 2'd0;
  localparam logic [1:0] IDX_XMOVE  = 2'd1;
  localparam logic [1:0] IDX_YMOVE  = 2'd2;

  // selection event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_START  = 2'd1;
  localparam logic [1:0] EV_EXTEND = 2'd2;
  localparam logic [1:0] EV_COPY   = 2'd3;

  // one complete three-byte packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } packet_t;

  // one result item
  typedef struct packed {
    logic [X_W-1:0]    cursor_x;
    logic [Y_W-1:0]    cursor_y;
    logic [ADDR_W-1:0] attr_address;
    logic              left_button;
    logic              right_button;
    logic [1:0]        select_event;
    logic              paste_request;
    logic [X_W-1:0]    sel_start_x;
    logic [Y_W-1:0]    sel_start_y;
    logic [X_W-1:0]    sel_end_x;
    logic [Y_W-1:0]    sel_end_y;
    logic              overflow;
  } result_t;

endpackage

// ----- sv/mpcs_assemble.sv -----
// groups incoming mouse bytes into three-byte packets
module mpcs_assemble import mpcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  output logic       in_ready,
  output logic       pkt_valid,
  output packet_t    pkt,
  input  logic       pkt_take
);

  logic [1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_move_r, x_move_nxt;
  logic       pkt_valid_r, pkt_valid_nxt;
  packet_t    pkt_r, pkt_nxt;
  logic       accept;

  // a byte can enter while the packet slot is free or being drained
  assign in_ready = !pkt_valid_r || pkt_take;
  assign accept   = in_valid && in_ready;

  // byte position tracking and packet capture
  always_comb begin
    byte_idx_nxt  = byte_idx_r;
    header_nxt    = header_r;
    x_move_nxt    = x_move_r;
    pkt_nxt       = pkt_r;
    pkt_valid_nxt = pkt_valid_r && !pkt_take;
    if (accept) begin
      case (byte_idx_r)
        IDX_XMOVE: begin
          x_move_nxt   = in_data_byte;
          byte_idx_nxt = IDX_YMOVE;
        end
        IDX_YMOVE: begin
          byte_idx_nxt   = IDX_HEADER;
          pkt_nxt.header = header_r;
          pkt_nxt.x_move = x_move_r;
          pkt_nxt.y_move = in_data_byte;
          pkt_valid_nxt  = 1'b1;
        end
        default: begin
          // unused index three is taken as a header too
          header_nxt   = in_data_byte;
          byte_idx_nxt = IDX_XMOVE;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= IDX_HEADER;
      pkt_valid_r <= 1'b0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      pkt_valid_r <= pkt_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    header_r <= header_nxt;
    x_move_r <= x_move_nxt;
    pkt_r    <= pkt_nxt;
  end

  assign pkt_valid = pkt_valid_r;
  assign pkt       = pkt_r;

endmodule

// ----- sv/mpcs_track.sv -----
// cursor, button and selection state, updated once per packet into a result register
module mpcs_track import mpcs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pkt_valid,
  input  packet_t pkt,
  output logic    pkt_take,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  localparam logic [X_W-1:0] XMAX = X_W'(COLUMNS - 1);
  localparam logic [Y_W-1:0] YMAX = Y_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

  logic [X_W-1:0]    pos_x_r, pos_x_nxt;
  logic [Y_W-1:0]    pos_y_r, pos_y_nxt;
  logic              left_r, left_nxt;
  logic              right_r, right_nxt;
  logic [X_W-1:0]    start_x_r, start_x_nxt;
  logic [Y_W-1:0]    start_y_r, start_y_nxt;
  logic [X_W-1:0]    end_x_r, end_x_nxt;
  logic [Y_W-1:0]    end_y_r, end_y_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;
  logic              ovf;
  logic [1:0]        sel_ev;
  logic              paste;
  logic [ADDR_W-1:0] cell_idx;

  // a packet moves on when the result register is free or being read
  assign pkt_take = pkt_valid && (!out_valid_r || out_ready);

  // packet decode, cursor move with clamping, selection events
  always_comb begin
    ovf       = pkt.header[HDR_XOVF] || pkt.header[HDR_YOVF];
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (!ovf) begin
      left_nxt  = pkt.header[HDR_LEFT];
      right_nxt = pkt.header[HDR_RIGHT];
      if (pkt.x_move != 8'd0) begin
        if (pkt.header[HDR_XSIGN]) begin
          pos_x_nxt = (pos_x_r == '0) ? '0 : pos_x_r - 1'b1;
        end else begin
          pos_x_nxt = (pos_x_r >= XMAX) ? XMAX : pos_x_r + 1'b1;
        end
      end
      if (pkt.y_move != 8'd0) begin
        if (pkt.header[HDR_YSIGN]) begin
          pos_y_nxt = (pos_y_r >= YMAX) ? YMAX : pos_y_r + 1'b1;
        end else begin
          pos_y_nxt = (pos_y_r == '0) ? '0 : pos_y_r - 1'b1;
        end
      end
    end

    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    end_x_nxt   = end_x_r;
    end_y_nxt   = end_y_r;
    sel_ev      = EV_NONE;
    if (left_nxt && !left_r) begin
      start_x_nxt = pos_x_nxt;
      start_y_nxt = pos_y_nxt;
      sel_ev      = EV_START;
    end else if (left_nxt && left_r) begin
      end_x_nxt = pos_x_nxt;
      end_y_nxt = pos_y_nxt;
      sel_ev    = EV_EXTEND;
    end else if (!left_nxt && left_r) begin
      end_x_nxt = pos_x_nxt;
      end_y_nxt = pos_y_nxt;
      sel_ev    = EV_COPY;
    end
    paste = right_nxt && !right_r;

    // attribute byte follows the character byte of each cell
    cell_idx = ADDR_W'(pos_x_nxt) + ADDR_W'(pos_y_nxt) * COLS_A;

    res_nxt               = res_r;
    out_valid_nxt         = out_valid_r && !out_ready;
    if (pkt_take) begin
      out_valid_nxt         = 1'b1;
      res_nxt.cursor_x      = pos_x_nxt;
      res_nxt.cursor_y      = pos_y_nxt;
      res_nxt.attr_address  = {cell_idx[ADDR_W-2:0], 1'b1};
      res_nxt.left_button   = left_nxt;
      res_nxt.right_button  = right_nxt;
      res_nxt.select_event  = sel_ev;
      res_nxt.paste_request = paste;
      res_nxt.sel_start_x   = start_x_nxt;
      res_nxt.sel_start_y   = start_y_nxt;
      res_nxt.sel_end_x     = end_x_nxt;
      res_nxt.sel_end_y     = end_y_nxt;
      res_nxt.overflow      = ovf;
    end
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      left_r      <= 1'b0;
      right_r     <= 1'b0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pkt_take) begin
        pos_x_r   <= pos_x_nxt;
        pos_y_r   <= pos_y_nxt;
        left_r    <= left_nxt;
        right_r   <= right_nxt;
        start_x_r <= start_x_nxt;
        start_y_r <= start_y_nxt;
        end_x_r   <= end_x_nxt;
        end_y_r   <= end_y_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // cursor stays on screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_x_r <= XMAX) && (pos_y_r <= YMAX))
    else $error("cursor left the screen");

  // overflow packet keeps the buttons, so no press or release event
  a_ovf_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.overflow) |->
      (res_r.select_event == EV_NONE || res_r.select_event == EV_EXTEND))
    else $error("selection edge on overflow packet");

  // paste only with the right button held
  a_paste_right: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.paste_request) |-> res_r.right_button)
    else $error("paste without right button");

  // result register loads only from a taken packet
  a_load_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(pkt_take))
    else $error("result appeared without a packet");

  // event code agrees with the reported left button
  a_event_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.select_event == EV_START || res_r.select_event == EV_EXTEND))
      |-> res_r.left_button)
    else $error("press or drag without left button");

endmodule

// ----- sv/mouse_packet_cursor_selection.sv -----
// mouse packet decoder: three-byte packets drive a text cursor and selection
// a packet is registered in the packet slot, then its result in the result register
// throughput: one byte per cycle while in_ready is high; one result per three bytes
// input stalls only while the packet slot and result register are full and out_ready is low
// reset (synchronous, rst_n low): byte position, cursor, buttons and cells go to zero
module mouse_packet_cursor_selection import mpcs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [X_W-1:0]    out_cursor_x,
  output logic [Y_W-1:0]    out_cursor_y,
  output logic [ADDR_W-1:0] out_attr_address,
  output logic              out_left_button,
  output logic              out_right_button,
  output logic [1:0]        out_select_event,
  output logic              out_paste_request,
  output logic [X_W-1:0]    out_sel_start_x,
  output logic [Y_W-1:0]    out_sel_start_y,
  output logic [X_W-1:0]    out_sel_end_x,
  output logic [Y_W-1:0]    out_sel_end_y,
  output logic              out_overflow
);

  logic    pkt_valid;
  logic    pkt_take;
  packet_t pkt;
  result_t res;

  // byte grouping
  mpcs_assemble u_assemble (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_ready     (in_ready),
    .pkt_valid    (pkt_valid),
    .pkt          (pkt),
    .pkt_take     (pkt_take)
  );

  // cursor and selection update
  mpcs_track #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_take  (pkt_take),
    .out_valid (out_valid),
    .out_res   (res),
    .out_ready (out_ready)
  );

  // result fields onto ports
  assign out_cursor_x      = res.cursor_x;
  assign out_cursor_y      = res.cursor_y;
  assign out_attr_address  = res.attr_address;
  assign out_left_button   = res.left_button;
  assign out_right_button  = res.right_button;
  assign out_select_event  = res.select_event;
  assign out_paste_request = res.paste_request;
  assign out_sel_start_x   = res.sel_start_x;
  assign out_sel_start_y   = res.sel_start_y;
  assign out_sel_end_x     = res.sel_end_x;
  assign out_sel_end_y     = res.sel_end_y;
  assign out_overflow      = res.overflow;

endmodule
